>>> design/mwe_pkg.sv
// Shared types, codes and helpers for the Microwire EEPROM master.
package mwe_pkg;

    localparam int TICK_W      = 16;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_BITS_W = 4;

    // Item kinds carried in the input tuser field; codes above EWDS are ticks too
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_EWEN  = 3'd3;
    localparam logic [OP_W-1:0] OP_EWDS  = 3'd4;

    // Microwire opcodes sent after the start bit
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_MISC  = 2'b00;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WAIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TRIES    = 3'd4;

    localparam logic [ADDR_BITS_W-1:0] MIN_ADDR_BITS = 4'd6;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_CS_UP    = 4'd1,
        PH_SK_LOW0  = 4'd2,
        PH_START_SK = 4'd3,
        PH_TX_LOW   = 4'd4,
        PH_TX_HIGH  = 4'd5,
        PH_RX_LOW   = 4'd6,
        PH_RX_HIGH  = 4'd7,
        PH_CS_DN_W  = 4'd8,
        PH_CS_UP_W  = 4'd9,
        PH_POLL     = 4'd10,
        PH_CS_FIN   = 4'd11,
        PH_CS_END   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUMMY    = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [ADDR_BITS_W-1:0] addr_bits;
        logic [7:0]             edge_wait_ticks;
        logic [TICK_W-1:0]      write_min_ticks;
        logic [TICK_W-1:0]      write_timeout_ticks;
        logic [3:0]             read_tries;
    } cfg_t;

    typedef struct packed {
        phase_t          phase;
        logic            half;       // 1 once the pin edge of this step is done
        logic [OP_W-1:0] cmd;
        status_t         err;
        logic [3:0]      tries;
        logic            prev_valid;
        logic            cs;
        logic            sk;
        logic            dout;
        logic            done;
    } ctrl_t;

    function automatic logic is_command(input logic [OP_W-1:0] op);
        return (op == OP_READ) || (op == OP_WRITE) || (op == OP_EWEN) || (op == OP_EWDS);
    endfunction

endpackage

>>> design/microwire_eeprom_master.sv
// Top level of the Microwire (93C-series) EEPROM master.
// Each input word is either a tick or a command (read, write, EWEN, EWDS) and
// yields exactly one output word with the pin levels, busy, done, the last read
// word and the status. The block takes one word per clock cycle unless the
// output stalls: a word is captured in an input register, the sequencer state
// is updated by one pass of the next-state logic and the result lands in an
// output register. Input is taken while a result waits, as long as the input
// register can move on; a stalled output holds both registers. Commands that
// arrive while a frame runs are dropped (they still return a result word) and
// do not count as ticks.
module microwire_eeprom_master #(
    parameter int DATA_BITS     = 16,
    parameter int MAX_ADDR_BITS = 10,
    localparam int IN_RAW       = MAX_ADDR_BITS + DATA_BITS + 1,
    localparam int IN_W         = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW      = 5 + DATA_BITS + 2,
    localparam int OUT_W        = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address, write_data, di_level
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // op
    input  logic [mwe_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cs_pin, sk_pin, do_pin, busy_res, done_res, read_result, status
    output logic [OUT_W-1:0]                m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [mwe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mwe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mwe_pkg::*;

    localparam int FRAME_W = 2 + MAX_ADDR_BITS + DATA_BITS;
    localparam int FL_W    = $clog2(FRAME_W + 1);

    cfg_t cfg;

    // input stage
    logic                     in_valid_reg;
    logic [OP_W-1:0]          in_op_reg;
    logic [MAX_ADDR_BITS-1:0] in_addr_reg;
    logic [DATA_BITS-1:0]     in_data_reg;
    logic                     in_di_reg;

    // sequencer state
    ctrl_t                    ctrl_reg,       ctrl_next;
    logic [FRAME_W-1:0]       frame_reg,      frame_next;
    logic [FL_W-1:0]          frame_len_reg,  frame_len_next;
    logic [FL_W-1:0]          bit_count_reg,  bit_count_next;
    logic [TICK_W-1:0]        tick_count_reg, tick_count_next;
    logic [DATA_BITS-1:0]     read_shift_reg, read_shift_next;
    logic [DATA_BITS-1:0]     prev_read_reg,  prev_read_next;
    logic [DATA_BITS-1:0]     read_word_reg,  read_word_next;

    // result stage
    logic                     out_valid_reg;
    logic [OUT_RAW-1:0]       out_word_reg;

    logic                     fire;
    logic                     in_take;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    mwe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwe_step #(
        .DATA_BITS     (DATA_BITS),
        .MAX_ADDR_BITS (MAX_ADDR_BITS)
    ) u_step (
        .cfg             (cfg),
        .op              (in_op_reg),
        .address         (in_addr_reg),
        .write_data      (in_data_reg),
        .di_level        (in_di_reg),
        .ctrl            (ctrl_reg),
        .frame           (frame_reg),
        .frame_len       (frame_len_reg),
        .bit_count       (bit_count_reg),
        .tick_count      (tick_count_reg),
        .read_shift      (read_shift_reg),
        .prev_read       (prev_read_reg),
        .read_word       (read_word_reg),
        .ctrl_next       (ctrl_next),
        .frame_next      (frame_next),
        .frame_len_next  (frame_len_next),
        .bit_count_next  (bit_count_next),
        .tick_count_next (tick_count_next),
        .read_shift_next (read_shift_next),
        .prev_read_next  (prev_read_next),
        .read_word_next  (read_word_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[MAX_ADDR_BITS-1:0];
            in_data_reg <= s_axis_tdata[MAX_ADDR_BITS +: DATA_BITS];
            in_di_reg   <= s_axis_tdata[MAX_ADDR_BITS + DATA_BITS];
        end
        if (fire)
        begin
            out_word_reg <= {ctrl_next.err, read_word_next, ctrl_next.done,
                             (ctrl_next.phase != PH_IDLE), ctrl_next.dout,
                             ctrl_next.sk, ctrl_next.cs};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase      <= PH_IDLE;
            ctrl_reg.half       <= 1'b0;
            ctrl_reg.cmd        <= OP_TICK;
            ctrl_reg.err        <= ST_OK;
            ctrl_reg.tries      <= 4'd0;
            ctrl_reg.prev_valid <= 1'b0;
            ctrl_reg.cs         <= 1'b0;
            ctrl_reg.sk         <= 1'b0;
            ctrl_reg.dout       <= 1'b0;
            ctrl_reg.done       <= 1'b0;
            frame_reg           <= '0;
            frame_len_reg       <= '0;
            bit_count_reg       <= '0;
            tick_count_reg      <= '0;
            read_shift_reg      <= '0;
            prev_read_reg       <= '0;
            read_word_reg       <= '0;
        end
        else if (fire)
        begin
            ctrl_reg       <= ctrl_next;
            frame_reg      <= frame_next;
            frame_len_reg  <= frame_len_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            read_shift_reg <= read_shift_next;
            prev_read_reg  <= prev_read_next;
            read_word_reg  <= read_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_word_reg);

    // a completing word never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg[4] |-> !out_word_reg[3])
        else $error("done and busy reported together");

    // write polling only happens with chip select raised again
    a_poll_cs_high: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == PH_POLL |-> ctrl_reg.cs)
        else $error("ready poll with CS low");

    // a command taken while idle opens a frame
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ctrl_reg.phase == PH_IDLE
        && (in_op_reg == OP_READ || in_op_reg == OP_WRITE
            || in_op_reg == OP_EWEN || in_op_reg == OP_EWDS)
        |=> ctrl_reg.phase == PH_CS_UP)
        else $error("command from idle did not start a frame");

endmodule

>>> design/mwe_cfg.sv
// Configuration register file for the Microwire EEPROM master.
module mwe_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mwe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mwe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mwe_pkg::cfg_t                    cfg
);
    import mwe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADDR_BITS:     cfg_next.addr_bits           = cfg_data[ADDR_BITS_W-1:0];
                CFG_EDGE_WAIT:     cfg_next.edge_wait_ticks     = cfg_data[7:0];
                CFG_WRITE_MIN:     cfg_next.write_min_ticks     = cfg_data[TICK_W-1:0];
                CFG_WRITE_TIMEOUT: cfg_next.write_timeout_ticks = cfg_data[TICK_W-1:0];
                CFG_READ_TRIES:    cfg_next.read_tries          = cfg_data[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.addr_bits           <= 4'd6;
            cfg_reg.edge_wait_ticks     <= 8'd1;
            cfg_reg.write_min_ticks     <= 16'd100;
            cfg_reg.write_timeout_ticks <= 16'd1100;
            cfg_reg.read_tries          <= 4'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/mwe_step.sv
// Next-state logic of the frame sequencer: one word in, one state update out.
module mwe_step #(
    parameter int DATA_BITS     = 16,
    parameter int MAX_ADDR_BITS = 10,
    localparam int FRAME_W      = 2 + MAX_ADDR_BITS + DATA_BITS,
    localparam int FL_W         = $clog2(FRAME_W + 1),
    localparam int IDX_W        = $clog2(FRAME_W)
) (
    input  mwe_pkg::cfg_t                  cfg,
    input  logic [mwe_pkg::OP_W-1:0]       op,
    input  logic [MAX_ADDR_BITS-1:0]       address,
    input  logic [DATA_BITS-1:0]           write_data,
    input  logic                           di_level,
    input  mwe_pkg::ctrl_t                 ctrl,
    input  logic [FRAME_W-1:0]             frame,
    input  logic [FL_W-1:0]                frame_len,
    input  logic [FL_W-1:0]                bit_count,
    input  logic [mwe_pkg::TICK_W-1:0]     tick_count,
    input  logic [DATA_BITS-1:0]           read_shift,
    input  logic [DATA_BITS-1:0]           prev_read,
    input  logic [DATA_BITS-1:0]           read_word,
    output mwe_pkg::ctrl_t                 ctrl_next,
    output logic [FRAME_W-1:0]             frame_next,
    output logic [FL_W-1:0]                frame_len_next,
    output logic [FL_W-1:0]                bit_count_next,
    output logic [mwe_pkg::TICK_W-1:0]     tick_count_next,
    output logic [DATA_BITS-1:0]           read_shift_next,
    output logic [DATA_BITS-1:0]           prev_read_next,
    output logic [DATA_BITS-1:0]           read_word_next
);
    import mwe_pkg::*;

    logic [7:0]                 edge_wait;
    logic [TICK_W-1:0]          tick_inc;
    logic [ADDR_BITS_W-1:0]     ab;
    logic [MAX_ADDR_BITS-1:0]   adr;
    logic [1:0]                 opc;
    logic [MAX_ADDR_BITS+1:0]   hdr;
    logic [FRAME_W-1:0]         full;
    logic [FL_W-1:0]            bit_sel;
    logic [FL_W-1:0]            bc_inc;
    logic [3:0]                 tries_inc;

    always_comb
    begin
        edge_wait = (cfg.edge_wait_ticks == 8'd0) ? 8'd1 : cfg.edge_wait_ticks;
        tick_inc  = (tick_count == {TICK_W{1'b1}}) ? tick_count : tick_count + 1'b1;
        bit_sel   = FL_W'(FRAME_W - 1) - bit_count;
        bc_inc    = bit_count + 1'b1;
        tries_inc = ctrl.tries + 1'b1;

        // address length is clamped and latched at the command
        if (cfg.addr_bits < MIN_ADDR_BITS)
            ab = MIN_ADDR_BITS;
        else if (cfg.addr_bits > ADDR_BITS_W'(MAX_ADDR_BITS))
            ab = ADDR_BITS_W'(MAX_ADDR_BITS);
        else
            ab = cfg.addr_bits;

        adr = address & ~({MAX_ADDR_BITS{1'b1}} << ab);
        case (op)
            OP_READ:  opc = OPC_READ;
            OP_WRITE: opc = OPC_WRITE;
            default:  opc = OPC_MISC;
        endcase
        if (op == OP_EWEN)
            adr = MAX_ADDR_BITS'(2'b11) << (ab - 4'd2);
        else if (op == OP_EWDS)
            adr = '0;
        hdr  = ((MAX_ADDR_BITS + 2)'(opc) << ab) | (MAX_ADDR_BITS + 2)'(adr);
        // left-align so the start of the frame sits at the top bit
        full = {hdr, (op == OP_WRITE) ? write_data : {DATA_BITS{1'b0}}};

        ctrl_next       = ctrl;
        ctrl_next.done  = 1'b0;
        frame_next      = frame;
        frame_len_next  = frame_len;
        bit_count_next  = bit_count;
        tick_count_next = tick_count;
        read_shift_next = read_shift;
        prev_read_next  = prev_read;
        read_word_next  = read_word;

        if (is_command(op))
        begin
            if (ctrl.phase == PH_IDLE)
            begin
                frame_next      = full << (ADDR_BITS_W'(MAX_ADDR_BITS) - ab);
                frame_len_next  = FL_W'(ab) + FL_W'(2)
                                  + ((op == OP_WRITE) ? FL_W'(DATA_BITS) : FL_W'(0));
                ctrl_next.cmd        = op;
                ctrl_next.err        = ST_OK;
                ctrl_next.tries      = 4'd0;
                ctrl_next.prev_valid = 1'b0;
                read_shift_next      = '0;
                bit_count_next       = '0;
                ctrl_next.phase      = PH_CS_UP;
                ctrl_next.half       = 1'b0;
                tick_count_next      = '0;
            end
        end
        else if (ctrl.phase != PH_IDLE)
        begin
            tick_count_next = tick_inc;
            if (ctrl.phase == PH_POLL)
            begin
                if (tick_inc >= cfg.write_timeout_ticks)
                begin
                    if (ctrl.err == ST_OK)
                        ctrl_next.err = ST_TIMEOUT;
                    ctrl_next.phase = PH_CS_FIN;
                    ctrl_next.half  = 1'b0;
                    tick_count_next = '0;
                end
                else if (tick_inc >= cfg.write_min_ticks && di_level)
                begin
                    ctrl_next.phase = PH_CS_FIN;
                    ctrl_next.half  = 1'b0;
                    tick_count_next = '0;
                end
            end
            else if (tick_inc >= {8'd0, edge_wait})
            begin
                tick_count_next = '0;
                if (!ctrl.half)
                begin
                    ctrl_next.half = 1'b1;
                    case (ctrl.phase)
                        PH_CS_UP, PH_CS_UP_W:            ctrl_next.cs = 1'b1;
                        PH_CS_DN_W, PH_CS_FIN, PH_CS_END: ctrl_next.cs = 1'b0;
                        PH_SK_LOW0, PH_TX_LOW, PH_RX_LOW: ctrl_next.sk = 1'b0;
                        default:                         ctrl_next.sk = 1'b1;
                    endcase
                end
                else
                begin
                    ctrl_next.half = 1'b0;
                    case (ctrl.phase)
                        PH_CS_UP:
                            ctrl_next.phase = PH_SK_LOW0;
                        PH_SK_LOW0:
                        begin
                            ctrl_next.dout  = 1'b1;
                            ctrl_next.phase = PH_START_SK;
                        end
                        PH_START_SK:
                        begin
                            bit_count_next  = '0;
                            ctrl_next.phase = PH_TX_LOW;
                        end
                        PH_TX_LOW:
                        begin
                            ctrl_next.dout  = frame[bit_sel[IDX_W-1:0]];
                            ctrl_next.phase = PH_TX_HIGH;
                        end
                        PH_TX_HIGH:
                        begin
                            if (bc_inc < frame_len)
                            begin
                                bit_count_next  = bc_inc;
                                ctrl_next.phase = PH_TX_LOW;
                            end
                            else
                            begin
                                ctrl_next.dout = 1'b0;
                                bit_count_next = '0;
                                if (ctrl.cmd == OP_READ)
                                begin
                                    // dummy bit must read low
                                    if (di_level && ctrl.err == ST_OK)
                                        ctrl_next.err = ST_DUMMY;
                                    ctrl_next.phase = PH_RX_LOW;
                                end
                                else if (ctrl.cmd == OP_WRITE)
                                    ctrl_next.phase = PH_CS_DN_W;
                                else
                                    ctrl_next.phase = PH_CS_END;
                            end
                        end
                        PH_RX_LOW:
                            ctrl_next.phase = PH_RX_HIGH;
                        PH_RX_HIGH:
                        begin
                            read_shift_next = {read_shift[DATA_BITS-2:0], di_level};
                            bit_count_next  = bc_inc;
                            ctrl_next.phase = (bc_inc < FL_W'(DATA_BITS)) ? PH_RX_LOW
                                                                           : PH_CS_END;
                        end
                        PH_CS_DN_W:
                            ctrl_next.phase = PH_CS_UP_W;
                        PH_CS_UP_W:
                            ctrl_next.phase = PH_POLL;
                        PH_CS_END:
                        begin
                            if (ctrl.cmd == OP_READ)
                            begin
                                ctrl_next.tries = tries_inc;
                                if (ctrl.prev_valid && prev_read == read_shift)
                                begin
                                    read_word_next  = read_shift;
                                    ctrl_next.phase = PH_IDLE;
                                    ctrl_next.done  = 1'b1;
                                end
                                else
                                begin
                                    prev_read_next       = read_shift;
                                    ctrl_next.prev_valid = 1'b1;
                                    if (tries_inc >= cfg.read_tries || tries_inc == 4'd0)
                                    begin
                                        read_word_next = read_shift;
                                        if (ctrl.err == ST_OK)
                                            ctrl_next.err = ST_NO_MATCH;
                                        ctrl_next.phase = PH_IDLE;
                                        ctrl_next.done  = 1'b1;
                                    end
                                    else
                                    begin
                                        read_shift_next = '0;
                                        ctrl_next.phase = PH_CS_UP;
                                    end
                                end
                            end
                            else
                            begin
                                ctrl_next.phase = PH_IDLE;
                                ctrl_next.done  = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctrl_next.phase = PH_IDLE;
                            ctrl_next.done  = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

endmodule
